### sv/cfl_color_probability_update_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the color probability update unit
// Shared property forms, clocked on clock and disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef CFL_COLOR_PROBABILITY_UPDATE_UNIT_ASSERT_SVH
`define CFL_COLOR_PROBABILITY_UPDATE_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CFL_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cfl: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define CFL_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cfl: next-cycle check failed");

`endif

### sv/cfl_pkg.sv
// ----------------------------------------------------------------------------
// cfl_pkg
// Types, constants and helper functions of the color probability update unit.
// ----------------------------------------------------------------------------
package cfl_pkg;

   // table geometry
   localparam int NODES    = 256;
   localparam int COLORS   = 16;
   localparam int NODE_W   = $clog2(NODES);
   localparam int COLOR_W  = $clog2(COLORS);
   localparam int ADDR_W   = NODE_W + COLOR_W;
   localparam int DEPTH    = NODES * COLORS;
   localparam int CNT_W    = 5;

   // arithmetic widths
   localparam int PROB_W   = 20;
   localparam int BETA_W   = 17;
   localparam int SUM_W    = 24;
   localparam int TGT_W    = 22;
   localparam int DVD_W    = 42;
   localparam int DVS_W    = 24;
   localparam int QUO_W    = 22;
   localparam int STEP_W   = 5;
   localparam int DIV_STEPS = QUO_W;
   localparam int SAT_W    = 23;

   localparam logic [PROB_W-1:0] PROB_MAX = {PROB_W{1'b1}};
   localparam logic [BETA_W-1:0] ONE_Q16  = BETA_W'(65536);
   localparam logic [PROB_W-1:0] UNIFORM_INIT = PROB_W'((65536 + COLORS / 2) / COLORS);
   localparam logic [CNT_W-1:0]  COLORS_LIM = CNT_W'(COLORS);

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;
   localparam int LR_RESET   = 6554;
   localparam int CC_RESET   = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARNING_RATE = 1'b0,
      CSR_COLOR_COUNT   = 1'b1
   } csr_reg_type;

   typedef enum logic {
      ACT_UPDATE = 1'b0,
      ACT_RESET  = 1'b1
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_LOAD,
      ST_FLUSH,
      ST_SUM,
      ST_SCALE,
      ST_SCALE_WAIT,
      ST_INC,
      ST_INC_WAIT,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic                 action;
      logic [NODE_W-1:0]    node_index;
      logic [15:0]          chosen_mask;
      logic [15:0]          neighbour_mask;
      logic [CNT_W-1:0]     requested_count;
   } req_item_type;

   typedef struct packed {
      logic [COLOR_W-1:0]   color_index;
      logic [PROB_W-1:0]    probability;
      logic [CNT_W-1:0]     conflict_count;
      logic                 conflict_free;
      logic                 last_color;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic                 capture;
      logic                 rd_en;
      logic                 div_start;
      logic                 div_inc;
      logic                 scale_wr;
      logic                 inc_wr;
      logic                 inc_direct_wr;
      logic                 wr_step;
      logic                 emit;
      logic                 row_done;
      logic [COLOR_W-1:0]   idx;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [CNT_W-1:0]     colors;
      logic                 is_reset;
      logic                 do_scale;
      logic                 inc_direct;
      logic                 div_done;
      logic                 div_busy;
      logic                 out_free;
   } dp_status_type;

   function automatic logic [CNT_W-1:0] popcount16(input logic [15:0] v);
      logic [CNT_W-1:0] n;
      n = '0;
      for (int k = 0; k < 16; k++) n = n + CNT_W'(v[k]);
      return n;
   endfunction

   function automatic logic [PROB_W-1:0] sat_prob(input logic [SAT_W-1:0] v);
      return (v > SAT_W'(PROB_MAX)) ? PROB_MAX : v[PROB_W-1:0];
   endfunction

   // round_half_up(65536 / c) for c = 1..16
   function automatic logic [PROB_W-1:0] uniform_prob(input logic [CNT_W-1:0] c);
      logic [PROB_W-1:0] u;
      case (c)
         5'd2:    u = 20'd32768;
         5'd3:    u = 20'd21845;
         5'd4:    u = 20'd16384;
         5'd5:    u = 20'd13107;
         5'd6:    u = 20'd10923;
         5'd7:    u = 20'd9362;
         5'd8:    u = 20'd8192;
         5'd9:    u = 20'd7282;
         5'd10:   u = 20'd6554;
         5'd11:   u = 20'd5958;
         5'd12:   u = 20'd5461;
         5'd13:   u = 20'd5041;
         5'd14:   u = 20'd4681;
         5'd15:   u = 20'd4369;
         5'd16:   u = 20'd4096;
         default: u = 20'd65536;
      endcase
      return u;
   endfunction

endpackage

### sv/cfl_req_if.sv
// ----------------------------------------------------------------------------
// cfl_req_if
// Request channel: one update or reset item per handshake.
// ----------------------------------------------------------------------------
interface cfl_req_if;
   logic                          valid;
   logic                          ready;
   logic                          action;
   logic [cfl_pkg::NODE_W-1:0]    node_index;
   logic [15:0]                   chosen_mask;
   logic [15:0]                   neighbour_mask;
   logic [cfl_pkg::CNT_W-1:0]     requested_count;

   modport source (output valid, action, node_index, chosen_mask, neighbour_mask,
                   requested_count, input ready);
   modport sink   (input valid, action, node_index, chosen_mask, neighbour_mask,
                   requested_count, output ready);
endinterface

### sv/cfl_rsp_if.sv
// ----------------------------------------------------------------------------
// cfl_rsp_if
// Result channel: one item per color of the node.
// ----------------------------------------------------------------------------
interface cfl_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cfl_pkg::COLOR_W-1:0]   color_index;
   logic [cfl_pkg::PROB_W-1:0]    probability;
   logic [cfl_pkg::CNT_W-1:0]     conflict_count;
   logic                          conflict_free;
   logic                          last_color;

   modport source (output valid, color_index, probability, conflict_count,
                   conflict_free, last_color, input ready);
   modport sink   (input valid, color_index, probability, conflict_count,
                   conflict_free, last_color, output ready);
endinterface

### sv/cfl_csr_if.sv
// ----------------------------------------------------------------------------
// cfl_csr_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface cfl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [cfl_pkg::CSR_IDX_W-1:0]    index;
   logic [cfl_pkg::CSR_DATA_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/cfl_ram.sv
// ----------------------------------------------------------------------------
// cfl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cfl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/cfl_div.sv
// ----------------------------------------------------------------------------
// cfl_div
// Restoring divider, one quotient bit per cycle. The quotient must fit in
// QUO_W bits, so only the low QUO_W dividend bits are walked.
// ----------------------------------------------------------------------------
module cfl_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [cfl_pkg::DVD_W-1:0]    dividend,
   input  logic [cfl_pkg::DVS_W-1:0]    divisor,
   output logic [cfl_pkg::QUO_W-1:0]    quotient,
   output logic                         busy,
   output logic                         done
);

   logic [cfl_pkg::DVS_W-1:0]  rem_ff, rem_in;
   logic [cfl_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [cfl_pkg::DVS_W-1:0]  dvs_ff, dvs_in;
   logic [cfl_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [cfl_pkg::DVS_W:0]    trial;
   logic                       ge;

   // one shift-and-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[cfl_pkg::QUO_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = cfl_pkg::DVS_W'(dividend[cfl_pkg::DVD_W-1:cfl_pkg::QUO_W]);
         quo_in  = dividend[cfl_pkg::QUO_W-1:0];
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? cfl_pkg::DVS_W'(trial - {1'b0, dvs_ff})
                     : trial[cfl_pkg::DVS_W-1:0];
         quo_in = {quo_ff[cfl_pkg::QUO_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == cfl_pkg::STEP_W'(cfl_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

### sv/cfl_dpath.sv
// ----------------------------------------------------------------------------
// cfl_dpath
// Datapath: config registers, item registers, probability RAM with row
// valid bits, per-node vector buffer, sum, divider and result register.
// ----------------------------------------------------------------------------
module cfl_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  cfl_pkg::ctrl_cmd_type            cmd,
   output cfl_pkg::dp_status_type           sts,
   input  cfl_pkg::req_item_type            req_item,
   input  logic                             csr_wr,
   input  logic [cfl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cfl_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                             rsp_valid,
   output cfl_pkg::rsp_item_type            rsp_item,
   input  logic                             rsp_ready
);

   logic [cfl_pkg::BETA_W-1:0]   lr_ff;
   logic [cfl_pkg::CNT_W-1:0]    cc_ff;
   logic                         action_ff;
   logic [cfl_pkg::NODE_W-1:0]   node_ff;
   logic [15:0]                  chosen_ff, clean_ff;
   logic [cfl_pkg::CNT_W-1:0]    m_ff, d_ff, conf_ff;
   logic [cfl_pkg::SUM_W-1:0]    sum_ff;
   logic [cfl_pkg::PROB_W-1:0]   vec_ff [cfl_pkg::COLORS];
   logic [cfl_pkg::PROB_W-1:0]   inc_ff;
   logic                         ld_pend_ff;
   logic [cfl_pkg::COLOR_W-1:0]  ld_idx_ff;
   logic [cfl_pkg::NODES-1:0]    row_vld_ff;
   logic                         rsp_valid_ff;
   cfl_pkg::rsp_item_type        rsp_ff;

   logic [cfl_pkg::CNT_W-1:0]    colors;
   logic [cfl_pkg::BETA_W-1:0]   beta;
   logic [15:0]                  cmask, chosen_m, neigh_m;
   logic [cfl_pkg::CNT_W-1:0]    m_clamp, n_clean;
   logic [cfl_pkg::CNT_W-1:0]    den;
   logic [cfl_pkg::TGT_W-1:0]    target;
   logic [cfl_pkg::DVD_W-1:0]    scale_dvd, inc_dvd, div_dvd;
   logic [cfl_pkg::DVS_W-1:0]    div_dvs;
   logic [cfl_pkg::QUO_W-1:0]    quotient;
   logic                         div_busy, div_done;
   logic [cfl_pkg::PROB_W-1:0]   vec_rd, ld_val, ram_rd, final_val, wr_val;
   logic                         row_vld, in_use, ram_we;
   logic [cfl_pkg::ADDR_W-1:0]   ram_addr;

   // effective configuration
   always_comb begin
      if (cc_ff == '0) begin
         colors = cfl_pkg::CNT_W'(1);
      end else if (cc_ff > cfl_pkg::COLORS_LIM) begin
         colors = cfl_pkg::COLORS_LIM;
      end else begin
         colors = cc_ff;
      end
      beta = (lr_ff > cfl_pkg::ONE_Q16) ? cfl_pkg::ONE_Q16 : lr_ff;
      for (int k = 0; k < 16; k++) cmask[k] = cfl_pkg::CNT_W'(k) < colors;
   end

   // item decode at capture
   always_comb begin
      chosen_m = req_item.chosen_mask & cmask;
      neigh_m  = req_item.neighbour_mask & cmask;
      m_clamp  = (req_item.requested_count > colors) ? colors : req_item.requested_count;
      n_clean  = cfl_pkg::popcount16(chosen_m & ~neigh_m);
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= cfl_pkg::BETA_W'(cfl_pkg::LR_RESET);
         cc_ff <= cfl_pkg::CNT_W'(cfl_pkg::CC_RESET);
      end else if (csr_wr) begin
         case (cfl_pkg::csr_reg_type'(csr_index))
            cfl_pkg::CSR_LEARNING_RATE: lr_ff <= csr_data;
            cfl_pkg::CSR_COLOR_COUNT:   lr_ff <= lr_ff;
            default:                    lr_ff <= lr_ff;
         endcase
         if (cfl_pkg::csr_reg_type'(csr_index) == cfl_pkg::CSR_COLOR_COUNT) begin
            cc_ff <= csr_data[cfl_pkg::CNT_W-1:0];
         end
      end
   end

   // item registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_item.action;
         node_ff   <= req_item.node_index;
         chosen_ff <= chosen_m;
         clean_ff  <= chosen_m & ~neigh_m;
         m_ff      <= m_clamp;
         d_ff      <= (n_clean >= m_clamp) ? '0 : m_clamp - n_clean;
         conf_ff   <= cfl_pkg::popcount16(chosen_m & neigh_m);
      end
   end

   // probability memory, addressed {node, color}
   assign row_vld  = row_vld_ff[node_ff];
   assign ram_addr = {node_ff, cmd.idx};
   assign in_use   = {1'b0, cmd.idx} < colors;

   cfl_ram #(
      .WIDTH (cfl_pkg::PROB_W),
      .DEPTH (cfl_pkg::DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_addr),
      .wr_data (wr_val),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_addr),
      .rd_data (ram_rd)
   );

   // row valid bits: an unwritten row reads as the reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
      end else if (cmd.row_done) begin
         row_vld_ff[node_ff] <= 1'b1;
      end
   end

   // load pass: capture read data into the vector, zero clean colors, sum
   assign ld_val = clean_ff[ld_idx_ff] ? '0 : (row_vld ? ram_rd : cfl_pkg::UNIFORM_INIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         ld_pend_ff <= 1'b0;
      end else begin
         ld_pend_ff <= cmd.rd_en;
      end
      ld_idx_ff <= cmd.idx;
      if (cmd.capture) begin
         sum_ff <= '0;
      end else if (ld_pend_ff) begin
         sum_ff <= sum_ff + cfl_pkg::SUM_W'(ld_val);
      end
      if (ld_pend_ff) begin
         vec_ff[ld_idx_ff] <= ld_val;
      end else if (cmd.scale_wr) begin
         vec_ff[cmd.idx] <= cfl_pkg::sat_prob(cfl_pkg::SAT_W'(quotient));
      end
      if (cmd.inc_wr) begin
         inc_ff <= cfl_pkg::sat_prob(cfl_pkg::SAT_W'(quotient));
      end else if (cmd.inc_direct_wr) begin
         inc_ff <= (d_ff != '0) ? cfl_pkg::PROB_MAX : '0;
      end
   end

   // divider operands: rescale or increment
   always_comb begin
      vec_rd    = vec_ff[cmd.idx];
      den       = colors - m_ff;
      target    = cfl_pkg::TGT_W'(cfl_pkg::ONE_Q16 - beta) * cfl_pkg::TGT_W'(d_ff);
      scale_dvd = cfl_pkg::DVD_W'(vec_rd) * cfl_pkg::DVD_W'(target)
                  + cfl_pkg::DVD_W'(sum_ff >> 1);
      inc_dvd   = cfl_pkg::DVD_W'(cfl_pkg::TGT_W'(beta) * cfl_pkg::TGT_W'(d_ff))
                  + cfl_pkg::DVD_W'(den >> 1);
      div_dvd   = cmd.div_inc ? inc_dvd : scale_dvd;
      div_dvs   = cmd.div_inc ? cfl_pkg::DVS_W'(den) : sum_ff;
   end

   cfl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .quotient (quotient),
      .busy     (div_busy),
      .done     (div_done)
   );

   // write pass: final value per color
   always_comb begin
      if (action_ff == cfl_pkg::ACT_RESET) begin
         final_val = cfl_pkg::uniform_prob(colors);
      end else if (!chosen_ff[cmd.idx]) begin
         final_val = cfl_pkg::sat_prob(cfl_pkg::SAT_W'(vec_rd) + cfl_pkg::SAT_W'(inc_ff));
      end else if (clean_ff[cmd.idx]) begin
         final_val = cfl_pkg::PROB_W'(cfl_pkg::ONE_Q16);
      end else begin
         final_val = vec_rd;
      end
      if (in_use) begin
         wr_val = final_val;
      end else if (action_ff == cfl_pkg::ACT_RESET) begin
         wr_val = '0;
      end else begin
         wr_val = cfl_pkg::UNIFORM_INIT;
      end
      ram_we = cmd.wr_step && (in_use || action_ff == cfl_pkg::ACT_RESET || !row_vld);
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_ff.color_index    <= cmd.idx;
         rsp_ff.probability    <= final_val;
         rsp_ff.conflict_count <= (action_ff == cfl_pkg::ACT_UPDATE) ? conf_ff : '0;
         rsp_ff.conflict_free  <= (action_ff == cfl_pkg::ACT_UPDATE) && (conf_ff == '0);
         rsp_ff.last_color     <= {1'b0, cmd.idx} == colors - 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // status
   always_comb begin
      sts.colors     = colors;
      sts.is_reset   = action_ff == cfl_pkg::ACT_RESET;
      sts.do_scale   = sum_ff != '0;
      sts.inc_direct = colors == m_ff;
      sts.div_done   = div_done;
      sts.div_busy   = div_busy;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

endmodule

### sv/cfl_ctrl.sv
// ----------------------------------------------------------------------------
// cfl_ctrl
// Sequencer: load pass, per-color rescale, increment, write/emit pass.
// ----------------------------------------------------------------------------
module cfl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  cfl_pkg::dp_status_type   sts,
   output cfl_pkg::ctrl_cmd_type    cmd
);

   cfl_pkg::state_type           state_ff, state_in;
   logic [cfl_pkg::COLOR_W-1:0]  idx_ff, idx_in;
   logic                         last_used, in_use, wr_go;

   assign last_used = {1'b0, idx_ff} == sts.colors - 1'b1;
   assign in_use    = {1'b0, idx_ff} < sts.colors;
   assign wr_go     = !in_use || sts.out_free;

   // next state
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      case (state_ff)
         cfl_pkg::ST_IDLE: begin
            if (req_valid) state_in = cfl_pkg::ST_START;
         end
         cfl_pkg::ST_START: begin
            idx_in   = '0;
            state_in = sts.is_reset ? cfl_pkg::ST_WRITE : cfl_pkg::ST_LOAD;
         end
         cfl_pkg::ST_LOAD: begin
            if (last_used) begin
               idx_in   = '0;
               state_in = cfl_pkg::ST_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         cfl_pkg::ST_FLUSH: begin
            state_in = cfl_pkg::ST_SUM;
         end
         cfl_pkg::ST_SUM: begin
            state_in = sts.do_scale ? cfl_pkg::ST_SCALE : cfl_pkg::ST_INC;
         end
         cfl_pkg::ST_SCALE: begin
            state_in = cfl_pkg::ST_SCALE_WAIT;
         end
         cfl_pkg::ST_SCALE_WAIT: begin
            if (sts.div_done) begin
               if (last_used) begin
                  idx_in   = '0;
                  state_in = cfl_pkg::ST_INC;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = cfl_pkg::ST_SCALE;
               end
            end
         end
         cfl_pkg::ST_INC: begin
            idx_in   = '0;
            state_in = sts.inc_direct ? cfl_pkg::ST_WRITE : cfl_pkg::ST_INC_WAIT;
         end
         cfl_pkg::ST_INC_WAIT: begin
            if (sts.div_done) state_in = cfl_pkg::ST_WRITE;
         end
         cfl_pkg::ST_WRITE: begin
            if (wr_go) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == cfl_pkg::COLOR_W'(cfl_pkg::COLORS - 1)) begin
                  state_in = cfl_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = cfl_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.idx   = idx_ff;
      req_ready = 1'b0;
      case (state_ff)
         cfl_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         cfl_pkg::ST_LOAD: begin
            cmd.rd_en = 1'b1;
         end
         cfl_pkg::ST_SCALE: begin
            cmd.div_start = 1'b1;
         end
         cfl_pkg::ST_SCALE_WAIT: begin
            cmd.scale_wr = sts.div_done;
         end
         cfl_pkg::ST_INC: begin
            cmd.div_inc       = 1'b1;
            cmd.div_start     = !sts.inc_direct;
            cmd.inc_direct_wr = sts.inc_direct;
         end
         cfl_pkg::ST_INC_WAIT: begin
            cmd.div_inc = 1'b1;
            cmd.inc_wr  = sts.div_done;
         end
         cfl_pkg::ST_WRITE: begin
            cmd.wr_step  = wr_go;
            cmd.emit     = wr_go && in_use;
            cmd.row_done = wr_go && (idx_ff == cfl_pkg::COLOR_W'(cfl_pkg::COLORS - 1));
         end
         default: begin
            cmd.idx = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfl_pkg::ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

### sv/cfl_color_probability_update_unit.sv
// ----------------------------------------------------------------------------
// cfl_color_probability_update_unit
// Per-node color probability update for channel-selection learning.
//
//   channel   direction  item
//   req_ch    in         action, node_index, chosen_mask, neighbour_mask,
//                        requested_count
//   rsp_ch    out        color_index, probability, conflict_count,
//                        conflict_free, last_color (one per color in use)
//   csr_ch    in         index, data (always ready)
//
// One item at a time. A reset item goes straight to the write pass. An update
// item runs the load pass, the rescale (skipped when the sum is zero), the
// increment (divided unless all colors are requested) and the write pass; the
// 22-step shared divider serves each rescaled color and the increment.
// Reset clears control and row valid bits; no clearing pass is needed.
// A stalled result holds the write pass; req_ch is ready only when idle.
// ----------------------------------------------------------------------------
`include "cfl_color_probability_update_unit_assert.svh"

module cfl_color_probability_update_unit (
   input  logic       clock,
   input  logic       reset,
   cfl_req_if.sink    req_ch,
   cfl_rsp_if.source  rsp_ch,
   cfl_csr_if.sink    csr_ch
);

   cfl_pkg::ctrl_cmd_type   cmd;
   cfl_pkg::dp_status_type  sts;
   cfl_pkg::req_item_type   req_item;
   cfl_pkg::rsp_item_type   rsp_item;
   logic                    req_ready;
   logic                    rsp_valid;

   // channel unpack
   always_comb begin
      req_item.action          = req_ch.action;
      req_item.node_index      = req_ch.node_index;
      req_item.chosen_mask     = req_ch.chosen_mask;
      req_item.neighbour_mask  = req_ch.neighbour_mask;
      req_item.requested_count = req_ch.requested_count;
   end

   assign req_ch.ready       = req_ready;
   assign csr_ch.ready       = 1'b1;
   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.color_index    = rsp_item.color_index;
   assign rsp_ch.probability    = rsp_item.probability;
   assign rsp_ch.conflict_count = rsp_item.conflict_count;
   assign rsp_ch.conflict_free  = rsp_item.conflict_free;
   assign rsp_ch.last_color     = rsp_item.last_color;

   cfl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   cfl_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_item  (req_item),
      .csr_wr    (csr_ch.valid),
      .csr_index (csr_ch.index),
      .csr_data  (csr_ch.data),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .rsp_ready (rsp_ch.ready)
   );

   // checks
   `CFL_ASSERT_SAME(a_emit_slot_free, cmd.emit, sts.out_free)
   `CFL_ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready)
   `CFL_ASSERT_SAME(a_div_idle_on_start, cmd.div_start, !sts.div_busy)

endmodule

### tb/cfl_tb_if.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Item types for the color probability update unit testbench
// The block's own interfaces are compiled with the RTL. This file only
// carries the shared item type that the checker uses to name a result.
// ----------------------------------------------------------------------------
package cfl_tb_pkg;
   import cfl_pkg::*;

   // one expected result item
   typedef struct packed {
      logic [COLOR_W-1:0] color_index;
      logic [PROB_W-1:0]  probability;
      logic [CNT_W-1:0]   conflict_count;
      logic               conflict_free;
      logic               last_color;
   } prob_result_type;
endpackage

### tb/cfl_prob_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Probability table checker
// Watches the request, result and register channels. It keeps its own copy of
// the per-node probability table, works out the results of each accepted
// item and compares every accepted result, field by field, in order.
// ----------------------------------------------------------------------------
module cfl_prob_checker (
   input  logic      clock,
   input  logic      reset,
   cfl_req_if        req_ch,
   cfl_rsp_if        rsp_ch,
   cfl_csr_if        csr_ch,
   output int        fail_count,
   output int        pending_count
);
   import cfl_pkg::*;
   import cfl_tb_pkg::*;

   logic [PROB_W-1:0]  prob_mem [NODES][COLORS];
   logic [BETA_W-1:0]  beta_reg;
   logic [CNT_W-1:0]   ccount_reg;
   prob_result_type    result_queue [$];

   function automatic logic [PROB_W-1:0] sat20(input longint unsigned v);
      return (v > 64'hFFFFF) ? PROB_MAX : v[PROB_W-1:0];
   endfunction

   // update one node's row and queue its results
   task automatic update_node(input logic act, input logic [NODE_W-1:0] node,
                              input logic [15:0] chm, input logic [15:0] nbm,
                              input logic [CNT_W-1:0] req_m);
      int unsigned c, m, n, d, conflicts;
      longint unsigned beta, total, tgt, inc, den;
      logic [15:0] cmask, chosen, neigh, clean;
      prob_result_type r;
      c = ccount_reg;
      if (c < 1) c = 1;
      if (c > COLORS) c = COLORS;
      cmask = 16'((32'd1 << c) - 1);
      beta = (beta_reg > ONE_Q16) ? 65536 : beta_reg;
      conflicts = 0;
      if (act == ACT_RESET) begin
         for (int j = 0; j < COLORS; j++)
            prob_mem[node][j] = (j < c) ? PROB_W'((65536 + c / 2) / c) : '0;
      end else begin
         chosen = chm & cmask;
         neigh = nbm & cmask;
         clean = chosen & ~neigh;
         m = (req_m > c) ? c : req_m;
         n = $countones(clean);
         conflicts = $countones(chosen & neigh);
         d = (n >= m) ? 0 : m - n;
         total = 0;
         for (int j = 0; j < c; j++) begin
            if (clean[j]) prob_mem[node][j] = '0;
            total += prob_mem[node][j];
         end
         tgt = (65536 - beta) * d;
         if (total != 0)
            for (int j = 0; j < c; j++)
               prob_mem[node][j] = sat20((prob_mem[node][j] * tgt + total / 2) / total);
         if (c == m) inc = (d > 0) ? 64'hFFFFF : 0;
         else begin
            den = c - m;
            inc = (beta * d + den / 2) / den;
         end
         for (int j = 0; j < c; j++)
            if (!chosen[j]) prob_mem[node][j] = sat20(prob_mem[node][j] + inc);
            else if (clean[j]) prob_mem[node][j] = PROB_W'(65536);
      end
      for (int j = 0; j < c; j++) begin
         r.color_index = COLOR_W'(j);
         r.probability = prob_mem[node][j];
         r.conflict_count = (act == ACT_UPDATE) ? CNT_W'(conflicts) : '0;
         r.conflict_free = (act == ACT_UPDATE) && (conflicts == 0);
         r.last_color = (j == c - 1);
         result_queue.insert(result_queue.size(), r);
      end
   endtask

   task automatic compare_result();
      prob_result_type e;
      if (result_queue.size() == 0) begin
         $error("result item with no expectation: color %0d", rsp_ch.color_index);
         fail_count++;
         return;
      end
      e = result_queue.pop_front();
      if (rsp_ch.color_index !== e.color_index) begin
         $error("color_index expected %0d actual %0d", e.color_index, rsp_ch.color_index);
         fail_count++;
      end
      if (rsp_ch.probability !== e.probability) begin
         $error("probability expected %0d actual %0d", e.probability, rsp_ch.probability);
         fail_count++;
      end
      if (rsp_ch.conflict_count !== e.conflict_count) begin
         $error("conflict_count expected %0d actual %0d", e.conflict_count,
                rsp_ch.conflict_count);
         fail_count++;
      end
      if (rsp_ch.conflict_free !== e.conflict_free) begin
         $error("conflict_free expected %0d actual %0d", e.conflict_free,
                rsp_ch.conflict_free);
         fail_count++;
      end
      if (rsp_ch.last_color !== e.last_color) begin
         $error("last_color expected %0d actual %0d", e.last_color, rsp_ch.last_color);
         fail_count++;
      end
   endtask

   // sample handshakes at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NODES; i++)
            for (int j = 0; j < COLORS; j++) prob_mem[i][j] = UNIFORM_INIT;
         beta_reg = BETA_W'(LR_RESET);
         ccount_reg = CNT_W'(CC_RESET);
         result_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) compare_result();
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == CSR_LEARNING_RATE) beta_reg = csr_ch.data;
            else ccount_reg = csr_ch.data[CNT_W-1:0];
         end
         if (req_ch.valid && req_ch.ready)
            update_node(req_ch.action, req_ch.node_index, req_ch.chosen_mask,
                        req_ch.neighbour_mask, req_ch.requested_count);
      end
      pending_count = result_queue.size();
   end
endmodule

### tb/cfl_color_probability_update_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Color probability update unit testbench
// Drives directed and random update and reset items over several register
// settings, with random idling on both channels; a checker module predicts
// and compares every result item.
// ----------------------------------------------------------------------------
module cfl_color_probability_update_unit_test;
   import cfl_pkg::*;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   bit   rsp_hold;
   bit   no_idle;

   cfl_req_if req_ch ();
   cfl_rsp_if rsp_ch ();
   cfl_csr_if csr_ch ();

   cfl_color_probability_update_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   cfl_prob_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: random stalls, or a long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) rsp_ch.ready <= 1'b0;
         else rsp_ch.ready <= no_idle || ($urandom_range(99) >= 9);
      end
   end

   task automatic send_item(input action_type act, input logic [NODE_W-1:0] node,
                            input logic [15:0] chm, input logic [15:0] nbm,
                            input logic [CNT_W-1:0] m);
      while (!no_idle && $urandom_range(99) < 9) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.action <= act;
      req_ch.node_index <= node;
      req_ch.chosen_mask <= chm;
      req_ch.neighbour_mask <= nbm;
      req_ch.requested_count <= m;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
   endtask

   // random update or reset item, with a well-formed request most of the time
   task automatic random_item(input int ccount);
      logic [15:0] chm, nbm;
      int m;
      if ($urandom_range(9) == 0) begin
         send_item(ACT_RESET, NODE_W'($urandom), 16'($urandom), 16'($urandom),
                   CNT_W'($urandom));
         return;
      end
      m = $urandom_range(ccount);
      chm = 16'($urandom) & 16'($urandom);
      nbm = 16'($urandom) & 16'($urandom);
      if ($urandom_range(9) == 0) m = $urandom_range(31);
      send_item(ACT_UPDATE, NODE_W'($urandom_range(7) + (($urandom_range(3) == 0) ?
                $urandom : 0)), chm, nbm, CNT_W'(m));
   endtask

   int lrates [6] = '{6554, 0, 65536, 131071, 32768, 1};
   int ccounts [6] = '{16, 1, 2, 0, 31, 5};

   initial begin
      reset = 1'b1;
      rsp_hold = 1'b0;
      no_idle = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.action = ACT_UPDATE;
      req_ch.node_index = '0;
      req_ch.chosen_mask = '0;
      req_ch.neighbour_mask = '0;
      req_ch.requested_count = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_LEARNING_RATE;
      csr_ch.data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset values, field extremes, every special case
      send_item(ACT_UPDATE, 8'd0, 16'h0001, 16'h0000, 5'd3);
      send_item(ACT_UPDATE, 8'd0, 16'h0001, 16'h0000, 5'd3);
      send_item(ACT_UPDATE, 8'd255, 16'hFFFF, 16'h0000, 5'd2);
      send_item(ACT_UPDATE, 8'd255, 16'h0000, 16'h0000, 5'd0);
      send_item(ACT_UPDATE, 8'd1, 16'hFFFF, 16'hFFFF, 5'd16);
      send_item(ACT_UPDATE, 8'd2, 16'h00F0, 16'h0030, 5'd31);
      send_item(ACT_UPDATE, 8'd3, 16'h0000, 16'hFFFF, 5'd16);
      send_item(ACT_UPDATE, 8'd3, 16'h0003, 16'h0000, 5'd16);
      send_item(ACT_RESET, 8'd3, 16'hFFFF, 16'hFFFF, 5'd31);
      send_item(ACT_UPDATE, 8'd4, 16'hAAAA, 16'h5555, 5'd8);
      send_item(ACT_UPDATE, 8'd4, 16'h5555, 16'h5555, 5'd15);
      // sender pauses until every result is back
      drain_results();

      // long receiver hold-off while items keep coming
      fork
         begin
            rsp_hold = 1'b1;
            repeat (2000) @(posedge clock);
            rsp_hold = 1'b0;
         end
         for (int i = 0; i < 4; i++) random_item(16);
      join
      drain_results();

      // random phases over register settings, one without idling
      for (int ph = 0; ph < 6; ph++) begin
         int cc;
         write_csr(CSR_LEARNING_RATE, CSR_DATA_W'(lrates[ph]));
         write_csr(CSR_COLOR_COUNT, CSR_DATA_W'(ccounts[ph]));
         cc = (ccounts[ph] < 1) ? 1 : (ccounts[ph] > 16 ? 16 : ccounts[ph]);
         no_idle = (ph == 2);
         send_item(ACT_RESET, 8'd5, 16'h0000, 16'h0000, 5'd0);
         for (int i = 0; i < 32; i++) random_item(cc);
         drain_results();
      end
      // back to full width with a random rate
      write_csr(CSR_LEARNING_RATE, CSR_DATA_W'($urandom_range(65536)));
      write_csr(CSR_COLOR_COUNT, CSR_DATA_W'(16));
      for (int i = 0; i < 12; i++) random_item(16);
      drain_results();

      if (fail_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
